/* rtl/av1_obu_header_parser_core_macros.svh */
// assertion macros for the obu header parser
`ifndef AV1_OBU_HEADER_PARSER_CORE_MACROS_SVH
`define AV1_OBU_HEADER_PARSER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define OBU_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
`define OBU_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define OBU_ASSERT_IMPL(lbl, pre, post, msg)
`define OBU_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

/* rtl/av1obu_pkg.sv */
// types, codes and type mapping for the obu header parser
`timescale 1ns / 1ps

package av1obu_pkg;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_EXT  = 2'd1,
    PH_SIZE = 2'd2
  } phase_t;

  localparam logic [1:0] ST_COMPLETE  = 2'd0;
  localparam logic [1:0] ST_TRUNCATED = 2'd1;
  localparam logic [1:0] ST_TOO_LONG  = 2'd2;

  localparam logic [3:0] TYPE_PADDING  = 4'd15;
  localparam logic [3:0] KIND_RESERVED = 4'd0;
  localparam logic [3:0] KIND_PADDING  = 4'd9;

  localparam int SIZE_W = 56;
  localparam int LEB_LANE_W = 7;
  localparam logic [3:0] MAX_HEADER_LEN = 4'd10;

  typedef struct packed {
    logic [3:0]        type_index;
    logic [3:0]        type_kind;
    logic              extension_present;
    logic              size_present;
    logic [2:0]        temporal_layer;
    logic [1:0]        spatial_layer;
    logic [SIZE_W-1:0] payload_size;
    logic [3:0]        header_length;
    logic [1:0]        parse_status;
    logic              reserved_violation;
  } result_t;

  function automatic logic [3:0] kind_of(input logic [3:0] idx);
    logic [3:0] kind;
    kind = KIND_RESERVED;
    if (idx == TYPE_PADDING) begin
      kind = KIND_PADDING;
    end else if (idx inside {[4'd1:4'd8]}) begin
      kind = idx;
    end
    return kind;
  endfunction

endpackage

/* rtl/av1_obu_header_parser_core.sv */
// obu header parser: byte-wide header parsing with a two-entry result buffer
`timescale 1ns / 1ps
// Usage
//   Input channel: one header byte per item on data_byte, with start_mark set on
//   the first byte of each header and end_of_data set on the last available byte.
//   Handshake: in_valid / in_stall, an item moves when valid is high and stall low.
//   Output channel: one result per header on the field ports, out_valid /
//   out_stall, raised when the header is complete, cut short, or its size field
//   runs past MAX_SIZE_BYTES bytes.
//   Throughput: one byte per cycle while in_stall is low; the header state is
//   updated in the cycle the byte is taken, so the next byte may follow directly.
//   Results: the result of the byte that closes a header is registered into the
//   output register, or into the skid entry while the output register is stalled.
//   Stall: results sit in an output register backed by one skid entry; input
//   keeps flowing while the output register waits, and in_stall rises only
//   once the skid entry is also occupied.
//   Reset: rst is synchronous and active high; it empties both result entries
//   and puts the parser back to waiting for a start byte.
//   Bytes without start_mark while no header is open are dropped silently.

`include "av1_obu_header_parser_core_macros.svh"

module av1_obu_header_parser_core #(
  parameter int MAX_SIZE_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        start_mark,
  input  logic        end_of_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  type_index,
  output logic [3:0]  type_kind,
  output logic        extension_present,
  output logic        size_present,
  output logic [2:0]  temporal_layer,
  output logic [1:0]  spatial_layer,
  output logic [55:0] payload_size,
  output logic [3:0]  header_length,
  output logic [1:0]  parse_status,
  output logic        reserved_violation
);

  localparam int LEB_CNT_W = $clog2(MAX_SIZE_BYTES + 1);

  av1obu_pkg::phase_t phase, phase_next;
  logic [3:0]                  held_type, held_type_next;
  logic                        held_ext, held_ext_next;
  logic                        held_size_flag, held_size_flag_next;
  logic [2:0]                  held_temporal, held_temporal_next;
  logic [1:0]                  held_spatial, held_spatial_next;
  logic [av1obu_pkg::SIZE_W-1:0] size_acc, size_acc_next;
  logic [LEB_CNT_W-1:0]        leb_cnt, leb_cnt_next;
  logic [3:0]                  consumed, consumed_next;
  logic                        violation, violation_next;

  logic                        accept;
  logic                        emit;
  logic [1:0]                  status;
  logic                        push;
  av1obu_pkg::result_t         res_new;
  av1obu_pkg::result_t         res_main;
  av1obu_pkg::result_t         res_skid;
  logic                        main_valid;
  logic                        skid_valid;

  assign in_stall = skid_valid;
  assign accept   = in_valid && !skid_valid;
  assign push     = accept && emit;

  // header state register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= av1obu_pkg::PH_IDLE;
      held_type      <= '0;
      held_ext       <= 1'b0;
      held_size_flag <= 1'b0;
      held_temporal  <= '0;
      held_spatial   <= '0;
      size_acc       <= '0;
      leb_cnt        <= '0;
      consumed       <= '0;
      violation      <= 1'b0;
    end else begin
      phase          <= phase_next;
      held_type      <= held_type_next;
      held_ext       <= held_ext_next;
      held_size_flag <= held_size_flag_next;
      held_temporal  <= held_temporal_next;
      held_spatial   <= held_spatial_next;
      size_acc       <= size_acc_next;
      leb_cnt        <= leb_cnt_next;
      consumed       <= consumed_next;
      violation      <= violation_next;
    end
  end

  // per-byte parse step
  always_comb begin
    phase_next          = phase;
    held_type_next      = held_type;
    held_ext_next       = held_ext;
    held_size_flag_next = held_size_flag;
    held_temporal_next  = held_temporal;
    held_spatial_next   = held_spatial;
    size_acc_next       = size_acc;
    leb_cnt_next        = leb_cnt;
    consumed_next       = consumed;
    violation_next      = violation;
    emit                = 1'b0;
    status              = av1obu_pkg::ST_COMPLETE;
    if (accept) begin
      if (start_mark) begin
        held_type_next      = data_byte[6:3];
        held_ext_next       = data_byte[2];
        held_size_flag_next = data_byte[1];
        held_temporal_next  = '0;
        held_spatial_next   = '0;
        size_acc_next       = '0;
        leb_cnt_next        = '0;
        consumed_next       = 4'd1;
        violation_next      = data_byte[7] | data_byte[0];
        if (data_byte[2]) begin
          phase_next = av1obu_pkg::PH_EXT;
        end else if (data_byte[1]) begin
          phase_next = av1obu_pkg::PH_SIZE;
        end else begin
          emit = 1'b1;
        end
        if (!emit && end_of_data) begin
          emit   = 1'b1;
          status = av1obu_pkg::ST_TRUNCATED;
        end
      end else begin
        case (phase)
          av1obu_pkg::PH_EXT: begin
            held_temporal_next = data_byte[7:5];
            held_spatial_next  = data_byte[4:3];
            if (|data_byte[2:0]) begin
              violation_next = 1'b1;
            end
            consumed_next = consumed + 4'd1;
            if (!held_size_flag) begin
              emit = 1'b1;
            end else begin
              phase_next = av1obu_pkg::PH_SIZE;
              if (end_of_data) begin
                emit   = 1'b1;
                status = av1obu_pkg::ST_TRUNCATED;
              end
            end
          end
          av1obu_pkg::PH_SIZE: begin
            // each size byte fills its own 7-bit lane
            for (int k = 0; k < MAX_SIZE_BYTES; k++) begin
              if (leb_cnt == LEB_CNT_W'(k)) begin
                size_acc_next[k*av1obu_pkg::LEB_LANE_W +: av1obu_pkg::LEB_LANE_W] =
                  data_byte[6:0];
              end
            end
            leb_cnt_next  = leb_cnt + LEB_CNT_W'(1);
            consumed_next = consumed + 4'd1;
            if (!data_byte[7]) begin
              emit = 1'b1;
            end else if (leb_cnt_next >= LEB_CNT_W'(MAX_SIZE_BYTES)) begin
              emit   = 1'b1;
              status = av1obu_pkg::ST_TOO_LONG;
            end else if (end_of_data) begin
              emit   = 1'b1;
              status = av1obu_pkg::ST_TRUNCATED;
            end
          end
          default: begin
          end
        endcase
      end
      if (emit) begin
        phase_next = av1obu_pkg::PH_IDLE;
      end
    end
  end

  always_comb begin
    res_new.type_index         = held_type_next;
    res_new.type_kind          = av1obu_pkg::kind_of(held_type_next);
    res_new.extension_present  = held_ext_next;
    res_new.size_present       = held_size_flag_next;
    res_new.temporal_layer     = held_temporal_next;
    res_new.spatial_layer      = held_spatial_next;
    res_new.payload_size       = size_acc_next;
    res_new.header_length      = consumed_next;
    res_new.parse_status       = status;
    res_new.reserved_violation = violation_next;
  end

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!main_valid || !out_stall) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid || !out_stall) begin
      if (skid_valid) begin
        res_main <= res_skid;
      end else if (push) begin
        res_main <= res_new;
      end
    end else if (push) begin
      res_skid <= res_new;
    end
  end

  assign out_valid          = main_valid;
  assign type_index         = res_main.type_index;
  assign type_kind          = res_main.type_kind;
  assign extension_present  = res_main.extension_present;
  assign size_present       = res_main.size_present;
  assign temporal_layer     = res_main.temporal_layer;
  assign spatial_layer      = res_main.spatial_layer;
  assign payload_size       = res_main.payload_size;
  assign header_length      = res_main.header_length;
  assign parse_status       = res_main.parse_status;
  assign reserved_violation = res_main.reserved_violation;

  `OBU_ASSERT_IMPL(a_skid_behind_main, skid_valid, main_valid,
                   "skid entry without main entry")
  `OBU_ASSERT_NEXT(a_stalled_result_kept, main_valid && out_stall, main_valid,
                   "stalled result dropped")
  `OBU_ASSERT_IMPL(a_open_header_length, phase != av1obu_pkg::PH_IDLE,
                   (consumed != 4'd0) && (consumed < av1obu_pkg::MAX_HEADER_LEN),
                   "open header byte count out of range")
  `OBU_ASSERT_IMPL(a_size_count_bound, phase == av1obu_pkg::PH_SIZE,
                   leb_cnt < LEB_CNT_W'(MAX_SIZE_BYTES),
                   "size byte count past limit")
  `OBU_ASSERT_IMPL(a_result_sane, main_valid,
                   (res_main.header_length != 4'd0) && (res_main.parse_status != 2'd3),
                   "result with bad length or status")

endmodule
